// ===== src/kfc_pkg.sv =====
// Shared types and constants for the keypad four-function calculator.
package kfc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX
  } kfc_state_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_ECHO      = 3'd1,
    ACT_SHOW      = 3'd2,
    ACT_CLR_SHOW  = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_DIV_ZERO  = 3'd5,
    ACT_UNKNOWN   = 3'd6
  } kfc_action_t;

  localparam logic [7:0] KEY_NONE  = 8'h6F;  // 'o'
  localparam logic [7:0] KEY_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] KEY_NINE  = 8'h39;  // '9'
  localparam logic [7:0] KEY_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] KEY_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] KEY_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] KEY_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] KEY_CLEAR = 8'h25;  // '%'
  localparam logic [7:0] KEY_EQ    = 8'h3D;  // '='

  localparam int unsigned SHOW_W = 16;

endpackage

// ===== src/keypad_four_function_calculator.sv =====
// Top level of the keypad four-function calculator.
//
// Input channel: in_valid / in_stall carry one key code word (in_key_code).
// A word is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result word per key:
// out_display_action, out_echo_char and out_shown_value.
// All keys but '=' with '*' or a nonzero '/' finish without step states;
// the result word is registered and shows in the cycle after acceptance.
// '=' with '*' or a nonzero '/' runs a shift-add multiply or restoring divide
// on one shared adder: the step state ST_MUL or ST_DIV, then the finishing
// state ST_FIX, which registers the result word.
// in_stall is high while an operation runs or a result word waits, so at most
// one key is in flight: a new key is not taken until the result word of the
// last one has left.
// Reset clears operands, result, flags, pending operator and the halt flag.
// While out_stall is high the result word holds and no new key is taken.
// A divide by zero halts the block: every later key gives no action until
// reset.
module keypad_four_function_calculator
  import kfc_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_display_action,
  output logic [7:0]  out_echo_char,
  output logic signed [SHOW_W-1:0] out_shown_value
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);

  kfc_state_t state_r, state_nxt;

  logic [W-1:0]  first_r, first_nxt;
  logic [W-1:0]  second_r, second_nxt;
  logic [W-1:0]  result_r, result_nxt;
  logic          entering_second_r, entering_second_nxt;
  logic          after_equals_r, after_equals_nxt;
  logic [7:0]    pending_op_r, pending_op_nxt;
  logic          halted_r, halted_nxt;

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  opb_r, opb_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic          neg_r, neg_nxt;
  logic          is_mul_r, is_mul_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_action_r, out_action_nxt;
  logic [7:0]    out_echo_r, out_echo_nxt;
  logic [SHOW_W-1:0] out_shown_r, out_shown_nxt;

  logic          in_fire;
  logic          is_digit;
  logic [W-1:0]  digit_w;
  logic [W-1:0]  entry_sel;
  logic [W-1:0]  entry_next;
  logic [W-1:0]  abs_a, abs_b;

  logic [W:0]    add_a, add_b;
  logic          add_cin;
  logic [W:0]    add_sum;

  logic [W:0]    div_shift;
  logic [W+SHOW_W-1:0] show_ext;

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_fire  = in_valid && !in_stall;

  assign is_digit   = (in_key_code >= KEY_ZERO) && (in_key_code <= KEY_NINE);
  assign digit_w    = W'(in_key_code - KEY_ZERO);
  assign entry_sel  = entering_second_r ? second_r : first_r;
  assign entry_next = (entry_sel << 3) + (entry_sel << 1) + digit_w;
  assign abs_a      = first_r[W-1]  ? (~first_r + W'(1))  : first_r;
  assign abs_b      = second_r[W-1] ? (~second_r + W'(1)) : second_r;
  assign div_shift  = {acc_r, quo_r[W-1]};

  assign add_sum = add_a + add_b + (W+1)'(add_cin);

  // Shared adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        add_a = {1'b0, first_r};
        if (pending_op_r == KEY_SUB) begin
          add_b   = {1'b0, ~second_r};
          add_cin = 1'b1;
        end else begin
          add_b = {1'b0, second_r};
        end
      end
      ST_MUL: begin
        add_a = {1'b0, acc_r};
        add_b = {1'b0, opb_r};
      end
      ST_DIV: begin
        add_a   = div_shift;
        add_b   = ~{1'b0, opb_r};
        add_cin = 1'b1;
      end
      ST_FIX: begin
        add_a   = {1'b0, ~quo_r};
        add_cin = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !halted_r && in_key_code == KEY_EQ && !after_equals_r) begin
          if (pending_op_r == KEY_MUL) begin
            state_nxt = ST_MUL;
          end else if (pending_op_r == KEY_DIV && second_r != '0) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_MUL, ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and result word
  always_comb begin
    first_nxt           = first_r;
    second_nxt          = second_r;
    result_nxt          = result_r;
    entering_second_nxt = entering_second_r;
    after_equals_nxt    = after_equals_r;
    pending_op_nxt      = pending_op_r;
    halted_nxt          = halted_r;
    acc_nxt             = acc_r;
    opb_nxt             = opb_r;
    quo_nxt             = quo_r;
    neg_nxt             = neg_r;
    is_mul_nxt          = is_mul_r;
    cnt_nxt             = cnt_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_action_nxt      = out_action_r;
    out_echo_nxt        = out_echo_r;
    out_shown_nxt       = out_shown_r;
    show_ext            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = ACT_NONE;
          out_echo_nxt   = '0;
          out_shown_nxt  = '0;
          if (!halted_r && in_key_code != KEY_NONE) begin
            priority if (is_digit) begin
              out_action_nxt = ACT_ECHO;
              out_echo_nxt   = in_key_code;
              if (entering_second_r) begin
                second_nxt = entry_next;
              end else begin
                first_nxt = entry_next;
              end
            end else if (in_key_code == KEY_EQ && !after_equals_r) begin
              priority if (pending_op_r == KEY_ADD || pending_op_r == KEY_SUB) begin
                result_nxt          = add_sum[W-1:0];
                show_ext            = {{SHOW_W{1'b0}}, add_sum[W-1:0]};
                out_action_nxt      = ACT_SHOW;
                out_shown_nxt       = show_ext[SHOW_W-1:0];
                first_nxt           = '0;
                second_nxt          = '0;
                entering_second_nxt = 1'b0;
                after_equals_nxt    = 1'b1;
              end else if (pending_op_r == KEY_MUL) begin
                out_valid_nxt = 1'b0;
                acc_nxt       = '0;
                opb_nxt       = first_r;
                quo_nxt       = second_r;
                is_mul_nxt    = 1'b1;
                cnt_nxt       = CW'(W - 1);
              end else if (pending_op_r == KEY_DIV) begin
                if (second_r == '0) begin
                  out_action_nxt = ACT_DIV_ZERO;
                  halted_nxt     = 1'b1;
                end else begin
                  out_valid_nxt = 1'b0;
                  acc_nxt       = '0;
                  opb_nxt       = abs_b;
                  quo_nxt       = abs_a;
                  neg_nxt       = first_r[W-1] ^ second_r[W-1];
                  is_mul_nxt    = 1'b0;
                  cnt_nxt       = CW'(W - 1);
                end
              end else begin
                show_ext            = {{SHOW_W{1'b0}}, result_r};
                out_action_nxt      = ACT_UNKNOWN;
                out_shown_nxt       = show_ext[SHOW_W-1:0];
                first_nxt           = '0;
                second_nxt          = '0;
                entering_second_nxt = 1'b0;
                after_equals_nxt    = 1'b1;
              end
            end else if (in_key_code == KEY_EQ) begin
              show_ext       = {{SHOW_W{1'b0}}, result_r};
              first_nxt      = result_r;
              out_action_nxt = ACT_CLR_SHOW;
              out_shown_nxt  = show_ext[SHOW_W-1:0];
            end else if (in_key_code == KEY_CLEAR) begin
              out_action_nxt      = ACT_CLEAR;
              entering_second_nxt = 1'b0;
              after_equals_nxt    = 1'b0;
            end else begin
              out_action_nxt      = ACT_ECHO;
              out_echo_nxt        = in_key_code;
              entering_second_nxt = 1'b1;
              after_equals_nxt    = 1'b0;
              pending_op_nxt      = in_key_code;
            end
          end
        end
      end
      ST_MUL: begin
        if (quo_r[0]) begin
          acc_nxt = add_sum[W-1:0];
        end
        opb_nxt = opb_r << 1;
        quo_nxt = quo_r >> 1;
        cnt_nxt = cnt_r - CW'(1);
      end
      ST_DIV: begin
        if (!add_sum[W]) begin
          acc_nxt = add_sum[W-1:0];
        end else begin
          acc_nxt = div_shift[W-1:0];
        end
        quo_nxt = {quo_r[W-2:0], ~add_sum[W]};
        cnt_nxt = cnt_r - CW'(1);
      end
      ST_FIX: begin
        if (is_mul_r) begin
          result_nxt = acc_r;
          show_ext   = {{SHOW_W{1'b0}}, acc_r};
        end else if (neg_r) begin
          result_nxt = add_sum[W-1:0];
          show_ext   = {{SHOW_W{1'b0}}, add_sum[W-1:0]};
        end else begin
          result_nxt = quo_r;
          show_ext   = {{SHOW_W{1'b0}}, quo_r};
        end
        out_valid_nxt       = 1'b1;
        out_action_nxt      = ACT_SHOW;
        out_echo_nxt        = '0;
        out_shown_nxt       = show_ext[SHOW_W-1:0];
        first_nxt           = '0;
        second_nxt          = '0;
        entering_second_nxt = 1'b0;
        after_equals_nxt    = 1'b1;
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      first_r           <= '0;
      second_r          <= '0;
      result_r          <= '0;
      entering_second_r <= 1'b0;
      after_equals_r    <= 1'b0;
      pending_op_r      <= '0;
      halted_r          <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      first_r           <= first_nxt;
      second_r          <= second_nxt;
      result_r          <= result_nxt;
      entering_second_r <= entering_second_nxt;
      after_equals_r    <= after_equals_nxt;
      pending_op_r      <= pending_op_nxt;
      halted_r          <= halted_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    opb_r        <= opb_nxt;
    quo_r        <= quo_nxt;
    neg_r        <= neg_nxt;
    is_mul_r     <= is_mul_nxt;
    cnt_r        <= cnt_nxt;
    out_action_r <= out_action_nxt;
    out_echo_r   <= out_echo_nxt;
    out_shown_r  <= out_shown_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_display_action = out_action_r;
  assign out_echo_char      = out_echo_r;
  assign out_shown_value    = out_shown_r;

endmodule

// ===== src/kfc_checker.sv =====
// Port-level checker for the keypad four-function calculator, with its bind.
module kfc_checker
  import kfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_display_action,
  input logic [7:0]  out_echo_char,
  input logic signed [SHOW_W-1:0] out_shown_value
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_display_action)
      && $stable(out_echo_char) && $stable(out_shown_value))
    else $error("stalled result word changed");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_display_action <= ACT_UNKNOWN)
    else $error("display action out of range");

  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_display_action != ACT_ECHO |-> out_echo_char == '0)
    else $error("echo char set without echo action");

  a_show_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_display_action == ACT_NONE || out_display_action == ACT_ECHO
      || out_display_action == ACT_CLEAR || out_display_action == ACT_DIV_ZERO)
      |-> out_shown_value == '0)
    else $error("shown value set without show action");

  // stall new keys while a result word waits
  a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("key taken while result word pending");

endmodule

bind keypad_four_function_calculator kfc_checker u_kfc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_display_action (out_display_action),
  .out_echo_char      (out_echo_char),
  .out_shown_value    (out_shown_value)
);
